/* sv/hcs_pkg.sv */
// ============================================================================
// hcs_pkg: shared types and constants of the header comment stripper
// Character codes, channel item layouts and the result descriptor that
// travels from the decode core to the result emitter.
// ============================================================================
package hcs_pkg;

    localparam int DEFAULT_MAX_DEPTH = 32;
    localparam int MAX_RESULTS       = 32;
    localparam int CAP_W             = 16;
    localparam int CNT_W             = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W             = $clog2(MAX_RESULTS);

    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } hdr_t;

    typedef struct packed {
        logic       main_valid;
        logic [7:0] main_byte;
        logic       comment_valid;
        logic [7:0] comment_byte;
        logic       last;
    } res_t;

    // Everything the emitter needs to play out the results of one item.
    typedef struct packed {
        logic             is_end;
        logic             empty;
        logic [CNT_W-1:0] count;
        res_t             r0;
        res_t             r1;
    } desc_t;

endpackage

/* sv/hcs_core.sv */
// ============================================================================
// hcs_core: parser state and per-item decode
// Holds quote, escape, nesting and capture state and turns one item into a
// result descriptor in a single pass; the state advances when step is high.
// ============================================================================
module hcs_core
    import hcs_pkg::*;
#(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  hdr_t             item,
    input  logic             step,
    input  logic [CAP_W-1:0] capacity,
    output desc_t            desc
);

    localparam int LVL_W = $clog2(MAX_DEPTH + 1);
    localparam int SUM_W = CAP_W + 2;

    logic             quote_reg, quote_next;
    logic             esc_reg, esc_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [LVL_W-1:0] rec_reg, rec_next;
    logic [CAP_W-1:0] cnt_reg, cnt_next;

    logic [SUM_W-1:0] room_base;
    logic             room3;
    logic             room4;
    logic [7:0]       c;
    logic [7:0]       m0, m1, k0, k1;
    logic [1:0]       mcnt, kcnt;

    assign c         = item.in_byte;
    assign room_base = {2'b00, cnt_reg} + SUM_W'(rec_reg);
    assign room3     = (room_base + SUM_W'(3)) < {2'b00, capacity};
    assign room4     = (room_base + SUM_W'(4)) < {2'b00, capacity};

    always_comb
    begin
        quote_next = quote_reg;
        esc_next   = esc_reg;
        lvl_next   = lvl_reg;
        rec_next   = rec_reg;
        cnt_next   = cnt_reg;
        m0   = '0;
        m1   = '0;
        k0   = '0;
        k1   = '0;
        mcnt = 2'd0;
        kcnt = 2'd0;
        desc = '0;

        if (item.end_of_string)
        begin
            quote_next  = 1'b0;
            esc_next    = 1'b0;
            lvl_next    = '0;
            rec_next    = '0;
            cnt_next    = '0;
            desc.is_end = 1'b1;
            if (rec_reg == '0)
            begin
                desc.empty = 1'b1;
                desc.count = CNT_W'(1);
            end
            else if (int'(rec_reg) > MAX_RESULTS)
            begin
                desc.count = CNT_W'(MAX_RESULTS);
            end
            else
            begin
                desc.count = CNT_W'(rec_reg);
            end
        end
        else
        begin
            priority if (esc_reg)
            begin
                esc_next = 1'b0;
                if (lvl_reg != '0)
                begin
                    if (room3)
                    begin
                        k0 = CH_BSLASH;
                        k1 = c;
                        kcnt = 2'd2;
                        cnt_next = cnt_reg + CAP_W'(2);
                    end
                end
                else
                begin
                    m0 = CH_BSLASH;
                    m1 = c;
                    mcnt = 2'd2;
                end
            end
            else if (c == CH_BSLASH && (quote_reg || lvl_reg != '0))
            begin
                esc_next = 1'b1;
            end
            else if (lvl_reg != '0)
            begin
                if (c == CH_CLOSE)
                begin
                    lvl_next = lvl_reg - LVL_W'(1);
                end
                else if (c == CH_OPEN && lvl_reg < LVL_W'(MAX_DEPTH))
                begin
                    lvl_next = lvl_reg + LVL_W'(1);
                end
                if (room3)
                begin
                    k0 = c;
                    kcnt = 2'd1;
                    cnt_next = cnt_reg + CAP_W'(1);
                    rec_next = lvl_next;
                end
                if (lvl_next == '0 && c != CH_CLOSE)
                begin
                    m0 = c;
                    mcnt = 2'd1;
                end
            end
            else if (c == CH_QUOTE)
            begin
                quote_next = ~quote_reg;
                m0 = c;
                mcnt = 2'd1;
            end
            else if (!quote_reg && c == CH_OPEN)
            begin
                lvl_next = LVL_W'(1);
                if (room4)
                begin
                    rec_next = LVL_W'(1);
                    if (cnt_reg != '0)
                    begin
                        k0 = CH_SPACE;
                        k1 = CH_OPEN;
                        kcnt = 2'd2;
                        cnt_next = cnt_reg + CAP_W'(2);
                    end
                    else
                    begin
                        k0 = CH_OPEN;
                        kcnt = 2'd1;
                        cnt_next = cnt_reg + CAP_W'(1);
                    end
                end
                m0 = CH_SPACE;
                mcnt = 2'd1;
            end
            else if (c != CH_CLOSE)
            begin
                m0 = c;
                mcnt = 2'd1;
            end
            else
            begin
                // A stray close at level zero is dropped without a result.
                mcnt = 2'd0;
            end

            desc.count = CNT_W'((mcnt > kcnt) ? mcnt : kcnt);
            desc.r0.main_valid    = (mcnt != 2'd0);
            desc.r0.main_byte     = m0;
            desc.r0.comment_valid = (kcnt != 2'd0);
            desc.r0.comment_byte  = k0;
            desc.r1.main_valid    = (mcnt == 2'd2);
            desc.r1.main_byte     = m1;
            desc.r1.comment_valid = (kcnt == 2'd2);
            desc.r1.comment_byte  = k1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg <= 1'b0;
            esc_reg   <= 1'b0;
            lvl_reg   <= '0;
            rec_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (step)
        begin
            quote_reg <= quote_next;
            esc_reg   <= esc_next;
            lvl_reg   <= lvl_next;
            rec_reg   <= rec_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* sv/hcs_emitter.sv */
// ============================================================================
// hcs_emitter: result register and sequencer
// Holds one descriptor; offers a result per cycle while res_ready is high.
// ============================================================================
module hcs_emitter
    import hcs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  desc_t desc,
    output logic  free,
    input  logic  load,
    output logic  res_valid,
    input  logic  res_ready,
    output res_t  res_item
);

    desc_t            desc_reg;
    logic             valid_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             final_res;

    assign final_res = ({1'b0, idx_reg} + CNT_W'(1)) == desc_reg.count;
    assign free      = !valid_reg || (res_ready && final_res);
    assign res_valid = valid_reg;
    assign idx_next  = idx_reg + IDX_W'(1);

    always_comb
    begin
        res_item = '0;
        if (desc_reg.is_end)
        begin
            res_item.comment_valid = !desc_reg.empty;
            res_item.comment_byte  = desc_reg.empty ? 8'h00 : CH_CLOSE;
            res_item.last          = final_res;
        end
        else if (idx_reg == '0)
        begin
            res_item = desc_reg.r0;
        end
        else
        begin
            res_item = desc_reg.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= (desc.count != '0);
            idx_reg   <= '0;
        end
        else if (valid_reg && res_ready)
        begin
            if (final_res)
            begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= desc;
        end
    end

    // The index never runs past the number of results in the descriptor.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ({1'b0, idx_reg} < desc_reg.count))
        else $error("result index beyond descriptor count");

    // A data item never yields more than two results.
    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !desc_reg.is_end) |-> (desc_reg.count <= CNT_W'(2)))
        else $error("data item descriptor with more than two results");

    // The last flag only closes an end-of-string item.
    a_last_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_item.last) |-> (desc_reg.is_end && final_res))
        else $error("last flag outside the final end-of-string result");

    // A new descriptor is only taken when the previous one is done.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load && valid_reg) |-> (res_ready && final_res))
        else $error("descriptor overwritten before its results were taken");

endmodule

/* sv/header_comment_stripper_unit.sv */
// ============================================================================
// header_comment_stripper_unit: streaming header comment remover
// Strips parenthesised comments from a header value and optionally captures
// the comment text on a second stream.
// ============================================================================
// Usage:
//   Header bytes enter as items on the hdr channel (valid/ready); an item
//   with end_of_string set closes the value and carries no byte. Results
//   leave on the res channel, each carrying up to one cleaned byte and up
//   to one captured comment byte; last marks the final result of an
//   end-of-string item.
//   cap_we/cap_wdata write the comment capacity; zero turns capture off.
//   Write it only while the block is idle.
// Result flow:
//   The first result of an item is offered once the item has passed from
//   the input register into the result register. The result register
//   plays out one result per cycle while res_ready is high; a byte causes
//   one or two results (or none), and an end-of-string item causes one
//   result per closing parenthesis, at most 32. The result sequencer sets
//   the rate.
// Reset and stalls:
//   Reset clears all parser state and the capacity, and empties both stages.
//   When the receiver holds res_ready low the current result stays on the
//   port; the input register still takes one more item, then hdr_ready
//   drops until the result register frees.
// ============================================================================
module header_comment_stripper_unit
    import hcs_pkg::*;
#(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             hdr_valid,
    output logic             hdr_ready,
    input  hdr_t             hdr_item,
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res_item,
    input  logic             cap_we,
    input  logic [CAP_W-1:0] cap_wdata
);

    // Input register: one item waits here while the core decodes it.
    hdr_t             item_reg;
    logic             item_valid_reg;
    logic [CAP_W-1:0] capacity_reg;

    desc_t desc;
    logic  emit_free;
    logic  step;

    // The core's state advances exactly when its descriptor is loaded.
    assign step      = item_valid_reg && emit_free;
    assign hdr_ready = !item_valid_reg || emit_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            capacity_reg   <= '0;
        end
        else
        begin
            if (hdr_ready)
            begin
                item_valid_reg <= hdr_valid;
            end
            if (cap_we)
            begin
                capacity_reg <= cap_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_valid && hdr_ready)
        begin
            item_reg <= hdr_item;
        end
    end

    hcs_core #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_reg),
        .step     (step),
        .capacity (capacity_reg),
        .desc     (desc)
    );

    hcs_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .desc      (desc),
        .free      (emit_free),
        .load      (step),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule
